// ===== hw/rtl/bst_pkg.sv =====
// ---------------------------------------------------------------------------
// Two-axis Bresenham stepper package
// Word types for the request and result channels, request codes and the
// reset value of the step delay register.
// ---------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  // Width of the request code, the target fields and the tick counter.
  localparam int unsigned REQ_WIDTH    = 2;
  localparam int unsigned TARGET_WIDTH = 32;
  localparam int unsigned TICK_WIDTH   = 32;

  // Step delay after reset, in microsecond ticks.
  localparam logic [TICK_WIDTH-1:0] STEP_DELAY_RESET = 32'd1000;

  // Request codes; the fourth code is unused and ignored.
  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_RESET = 2'd2
  } req_code_t;

  // One request word.
  typedef struct packed {
    logic [REQ_WIDTH-1:0]           req_type;
    logic signed [TARGET_WIDTH-1:0] target_x;
    logic signed [TARGET_WIDTH-1:0] target_y;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic step_x;
    logic dir_x;
    logic step_y;
    logic dir_y;
    logic done_res;
    logic segment_active;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bst_core.sv =====
// ---------------------------------------------------------------------------
// Two-axis Bresenham stepper core
// Holds the segment state and works out one request word combinationally:
// arming a segment, the tick delay and the Bresenham step of both axes.
// ---------------------------------------------------------------------------
`default_nettype none

module bst_core
  import bst_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire in_word_t              req_word,
  input  wire logic [TICK_WIDTH-1:0] step_delay,
  output out_word_t                  res_word
);

  localparam int unsigned DW = POS_WIDTH + 1;  // signed difference and error
  localparam int unsigned EW = POS_WIDTH + 2;  // error while it is corrected

  // Segment state.
  logic [POS_WIDTH-1:0]  pos_x_r, pos_y_r, goal_x_r, goal_y_r;
  logic [POS_WIDTH-1:0]  delta_x_r, delta_y_r;
  logic                  sign_x_r, sign_y_r, x_major_r, active_r;
  logic [DW-1:0]         line_error_r;
  logic [TICK_WIDTH-1:0] elapsed_r;

  logic [POS_WIDTH-1:0]  pos_x_nxt, pos_y_nxt, goal_x_nxt, goal_y_nxt;
  logic [POS_WIDTH-1:0]  delta_x_nxt, delta_y_nxt;
  logic                  sign_x_nxt, sign_y_nxt, x_major_nxt, active_nxt;
  logic [DW-1:0]         line_error_nxt;
  logic [TICK_WIDTH-1:0] elapsed_nxt;

  // Arming: goal source, signed differences, magnitudes and directions.
  logic                 is_start;
  logic [POS_WIDTH-1:0] tgt_x, tgt_y, src_x, src_y;
  logic [DW-1:0]        diff_x, diff_y;
  logic [POS_WIDTH-1:0] arm_dx, arm_dy, arm_dmaj;
  logic                 arm_sx, arm_sy, arm_xmaj;

  assign is_start = (req_word.req_type == REQ_START);
  assign tgt_x    = POS_WIDTH'($signed(req_word.target_x));
  assign tgt_y    = POS_WIDTH'($signed(req_word.target_y));
  assign src_x    = is_start ? tgt_x : goal_x_r;
  assign src_y    = is_start ? tgt_y : goal_y_r;

  assign diff_x   = {src_x[POS_WIDTH-1], src_x} - {pos_x_r[POS_WIDTH-1], pos_x_r};
  assign diff_y   = {src_y[POS_WIDTH-1], src_y} - {pos_y_r[POS_WIDTH-1], pos_y_r};
  assign arm_dx   = diff_x[DW-1] ? POS_WIDTH'(~diff_x + DW'(1)) : diff_x[POS_WIDTH-1:0];
  assign arm_dy   = diff_y[DW-1] ? POS_WIDTH'(~diff_y + DW'(1)) : diff_y[POS_WIDTH-1:0];
  assign arm_sx   = !diff_x[DW-1] && (diff_x != '0);
  assign arm_sy   = !diff_y[DW-1] && (diff_y != '0);
  assign arm_xmaj = (arm_dx >= arm_dy);
  assign arm_dmaj = arm_xmaj ? arm_dx : arm_dy;

  // Tick delay: saturating counter compared with the configured delay.
  logic [TICK_WIDTH-1:0] elapsed_inc;
  logic                  due;

  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + TICK_WIDTH'(1);
  assign due         = (elapsed_inc >= step_delay);

  // Bresenham step of the major axis and error correction of the minor one.
  logic [POS_WIDTH-1:0] dmaj, dmin;
  logic                 maj_off, min_off, at_goal, move;
  logic [EW-1:0]        err_sub, err_add;
  logic                 err_neg, min_step, stp_x, stp_y;
  logic [POS_WIDTH-1:0] step_pos_x, step_pos_y;
  logic                 at_goal_after;

  assign dmaj     = x_major_r ? delta_x_r : delta_y_r;
  assign dmin     = x_major_r ? delta_y_r : delta_x_r;
  assign maj_off  = x_major_r ? (pos_x_r != goal_x_r) : (pos_y_r != goal_y_r);
  assign min_off  = x_major_r ? (pos_y_r != goal_y_r) : (pos_x_r != goal_x_r);
  assign at_goal  = (pos_x_r == goal_x_r) && (pos_y_r == goal_y_r);
  assign move     = due && maj_off;

  assign err_sub  = {line_error_r[DW-1], line_error_r} - {2'b00, dmin};
  assign err_neg  = err_sub[EW-1];
  assign err_add  = err_sub + {2'b00, dmaj};
  assign min_step = err_neg && min_off;

  assign stp_x    = move && (x_major_r || min_step);
  assign stp_y    = move && (!x_major_r || min_step);

  assign step_pos_x = !stp_x ? pos_x_r :
                      (sign_x_r ? pos_x_r + POS_WIDTH'(1) : pos_x_r - POS_WIDTH'(1));
  assign step_pos_y = !stp_y ? pos_y_r :
                      (sign_y_r ? pos_y_r + POS_WIDTH'(1) : pos_y_r - POS_WIDTH'(1));
  assign at_goal_after = (step_pos_x == goal_x_r) && (step_pos_y == goal_y_r);

  // Next state and result word for the request in hand.
  always_comb begin
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    delta_x_nxt    = delta_x_r;
    delta_y_nxt    = delta_y_r;
    sign_x_nxt     = sign_x_r;
    sign_y_nxt     = sign_y_r;
    x_major_nxt    = x_major_r;
    active_nxt     = active_r;
    line_error_nxt = line_error_r;
    elapsed_nxt    = elapsed_r;
    res_word       = '0;

    unique case (req_word.req_type)
      REQ_START: begin
        goal_x_nxt = tgt_x;
        goal_y_nxt = tgt_y;
      end
      REQ_RESET: begin
        active_nxt = 1'b0;
      end
      REQ_TICK: begin
        if (at_goal) begin
          active_nxt        = 1'b0;
          res_word.done_res = 1'b1;
        end else if (active_r) begin
          elapsed_nxt = move || due ? '0 : elapsed_inc;
          if (move) begin
            pos_x_nxt      = step_pos_x;
            pos_y_nxt      = step_pos_y;
            line_error_nxt = err_neg ? err_add[DW-1:0] : err_sub[DW-1:0];
          end
          if (at_goal_after) begin
            active_nxt        = 1'b0;
            res_word.done_res = 1'b1;
          end
          res_word.step_x = stp_x;
          res_word.step_y = stp_y;
        end
      end
      default: begin
      end
    endcase

    // A start word, or a tick that finds the segment idle off target, arms it.
    if (is_start ||
        (req_word.req_type == REQ_TICK && !at_goal && !active_r)) begin
      delta_x_nxt    = arm_dx;
      delta_y_nxt    = arm_dy;
      sign_x_nxt     = arm_sx;
      sign_y_nxt     = arm_sy;
      x_major_nxt    = arm_xmaj;
      line_error_nxt = {1'b0, arm_dmaj >> 1};
      elapsed_nxt    = '0;
      active_nxt     = 1'b1;
    end

    res_word.dir_x          = sign_x_nxt;
    res_word.dir_y          = sign_y_nxt;
    res_word.segment_active = active_nxt;
  end

  // State registers, updated once for each word that passes through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      delta_x_r    <= '0;
      delta_y_r    <= '0;
      sign_x_r     <= 1'b0;
      sign_y_r     <= 1'b0;
      x_major_r    <= 1'b1;
      active_r     <= 1'b0;
      line_error_r <= '0;
      elapsed_r    <= '0;
    end else if (fire) begin
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      delta_x_r    <= delta_x_nxt;
      delta_y_r    <= delta_y_nxt;
      sign_x_r     <= sign_x_nxt;
      sign_y_r     <= sign_y_nxt;
      x_major_r    <= x_major_nxt;
      active_r     <= active_nxt;
      line_error_r <= line_error_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_axis_bresenham_stepper.sv =====
// ---------------------------------------------------------------------------
// Two-axis Bresenham stepper
// Line interpolator that turns start, tick and reset words into step and
// direction pulses for two motors.
// ---------------------------------------------------------------------------
// Usage:
//   Request words enter on in_valid/in_stall/in_word. A start word loads the
//   target, a tick word stands for one microsecond and a reset word stops the
//   segment. Every request word yields exactly one result word on
//   out_valid/out_stall/out_word, in order.
//   A word is taken at a clock edge with valid high and stall low.
//   A word lands in the input register, is worked out against the segment
//   state and is written into the output register together with the state
//   update. Throughput is one word per cycle while out_stall stays low; the
//   core updates its state registers once for each word that moves on.
//   While the receiver stalls, the output word holds and the input register
//   keeps the next word; in_stall rises only when both registers are full.
//   The step delay is written through cfg_wr_en/cfg_wr_data; the user must
//   write it only while no word is in flight, which the block does not enforce.
//   Synchronous reset clears both registers, the segment state and sets the
//   step delay to 1000 ticks; a word may be sent in the first cycle after it.
// ---------------------------------------------------------------------------
`default_nettype none

module two_axis_bresenham_stepper
  import bst_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TICK_WIDTH-1:0] cfg_wr_data
);

  logic                  req_valid_r;
  in_word_t              req_word_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;
  out_word_t             res_word;
  logic [TICK_WIDTH-1:0] step_delay_r;
  logic                  fire;
  logic                  in_take;

  // A held word moves on whenever the output register is free or draining.
  assign fire     = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  // Step delay register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_delay_r <= STEP_DELAY_RESET;
    end else if (cfg_wr_en) begin
      step_delay_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (fire) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_word_r <= in_word;
    end
  end

  // Segment state and step logic.
  bst_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req_word   (req_word_r),
    .step_delay (step_delay_r),
    .res_word   (res_word)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bst_checker.sv =====
// ---------------------------------------------------------------------------
// Two-axis Bresenham stepper checker
// Port-level assertions for the stepper, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bst_checker
  import bst_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // A word that reports the target reached never shows the segment active.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.done_res && out_word.segment_active))
    else $error("done reported with segment still active");

  // A step that does not finish the segment leaves it active.
  a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.step_x || out_word.step_y) && !out_word.done_res
      |-> out_word.segment_active)
    else $error("step reported on an inactive segment");

  // Reset empties both registers: nothing is shown and a word can be taken.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind two_axis_bresenham_stepper bst_checker u_bst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
